@@ rtl/cobs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_pkg
// Shared types, constants and the CRC-16-CCITT byte step for the COBS
// frame decoder.
// ----------------------------------------------------------------------------
package cobs_pkg;

	localparam int unsigned MAX_BODY_BYTES_DEF = 256;
	localparam int unsigned HEADER_LEN         = 4;
	localparam int unsigned CRC_LEN            = 2;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [7:0]  VER_RESET  = 8'd1;
	localparam logic [7:0]  CODE_FULL  = 8'hFF;
	localparam logic [8:0]  COUNT_MAX  = 9'h1FF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_COBS  = 3'd1,
		ST_SHORT     = 3'd2,
		ST_LONG      = 3'd3,
		ST_BAD_CRC   = 3'd4,
		ST_BAD_VER   = 3'd5
	} status_t;

	typedef enum logic {
		KIND_BODY   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// one result of a decode step
	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [7:0]  body;
		status_t     status;
		logic [7:0]  msg_type;
		logic [15:0] seq;
		logic [8:0]  len;
	} result_t;

	// msb-first crc-16-ccitt over one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/cobs_frame_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_frame_core
// Frame state and single-step decode: COBS unstuffing, two-byte CRC delay
// line, header capture and end-of-frame status.
// ----------------------------------------------------------------------------
module cobs_frame_core #(
	parameter int unsigned MAX_BODY_BYTES = cobs_pkg::MAX_BODY_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        byte_in,
	input  wire logic [7:0]        version,
	output cobs_pkg::result_t      res
);

	localparam logic [8:0] LONG_LIMIT =
		9'(MAX_BODY_BYTES + cobs_pkg::HEADER_LEN + cobs_pkg::CRC_LEN);
	localparam logic [8:0] MIN_LEN = 9'(cobs_pkg::HEADER_LEN + cobs_pkg::CRC_LEN);
	localparam logic [8:0] HDR_OVH = 9'(cobs_pkg::HEADER_LEN + cobs_pkg::CRC_LEN);

	logic [7:0]  rem_q, rem_d;
	logic        full_q, full_d;
	logic        zpend_q, zpend_d;
	logic [8:0]  count_q, count_d;
	logic [7:0]  tail0_q, tail0_d, tail1_q, tail1_d;
	logic [15:0] crc_q, crc_d;
	logic        vmatch_q, vmatch_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] seq_q, seq_d;

	logic        term;
	logic        push;
	logic [7:0]  pb;
	cobs_pkg::status_t status;

	always_comb begin
		term     = (byte_in == 8'h00);
		rem_d    = rem_q;
		full_d   = full_q;
		zpend_d  = zpend_q;
		count_d  = count_q;
		tail0_d  = tail0_q;
		tail1_d  = tail1_q;
		crc_d    = crc_q;
		vmatch_d = vmatch_q;
		type_d   = type_q;
		seq_d    = seq_q;
		push     = 1'b0;
		pb       = byte_in;
		status   = cobs_pkg::ST_OK;

		res          = '0;
		res.kind     = cobs_pkg::KIND_BODY;
		res.status   = cobs_pkg::ST_OK;

		if (term) begin
			if (rem_q != 8'd0) begin
				status = cobs_pkg::ST_BAD_COBS;
			end else if (count_q < MIN_LEN) begin
				status = cobs_pkg::ST_SHORT;
			end else if (count_q > LONG_LIMIT) begin
				status = cobs_pkg::ST_LONG;
			end else if ({tail1_q, tail0_q} != crc_q) begin
				status = cobs_pkg::ST_BAD_CRC;
			end else if (!vmatch_q) begin
				status = cobs_pkg::ST_BAD_VER;
			end
			res.emit     = 1'b1;
			res.kind     = cobs_pkg::KIND_STATUS;
			res.status   = status;
			res.msg_type = type_q;
			res.seq      = seq_q;
			res.len      = (status == cobs_pkg::ST_OK) ? (count_q - HDR_OVH) : 9'd0;
			// frame state back to reset
			rem_d    = 8'd0;
			full_d   = 1'b0;
			zpend_d  = 1'b0;
			count_d  = 9'd0;
			tail0_d  = 8'd0;
			tail1_d  = 8'd0;
			crc_d    = cobs_pkg::CRC_INIT;
			vmatch_d = 1'b0;
			type_d   = 8'd0;
			seq_d    = 16'd0;
		end else begin
			if (rem_q == 8'd0) begin
				// code byte: owed zero from the previous short block goes in first
				push    = zpend_q;
				pb      = 8'h00;
				rem_d   = byte_in - 8'd1;
				full_d  = (byte_in == cobs_pkg::CODE_FULL);
				zpend_d = (byte_in == 8'd1);
			end else begin
				push    = 1'b1;
				rem_d   = rem_q - 8'd1;
				zpend_d = (rem_q == 8'd1) && !full_q;
			end

			if (push) begin
				case (count_q)
					9'd0: vmatch_d = (pb == version);
					9'd1: type_d = pb;
					9'd2: seq_d = {seq_q[15:8], pb};
					9'd3: seq_d = {pb, seq_q[7:0]};
					default: ;
				endcase
				if (count_q >= 9'(cobs_pkg::CRC_LEN)) begin
					crc_d = cobs_pkg::crc_feed(crc_q, tail0_q);
					if (count_q >= HDR_OVH) begin
						res.emit = 1'b1;
						res.body = tail0_q;
					end
				end
				tail0_d = tail1_q;
				tail1_d = pb;
				if (count_q != cobs_pkg::COUNT_MAX) begin
					count_d = count_q + 9'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= 8'd0;
			full_q   <= 1'b0;
			zpend_q  <= 1'b0;
			count_q  <= 9'd0;
			tail0_q  <= 8'd0;
			tail1_q  <= 8'd0;
			crc_q    <= cobs_pkg::CRC_INIT;
			vmatch_q <= 1'b0;
			type_q   <= 8'd0;
			seq_q    <= 16'd0;
		end else if (step) begin
			rem_q    <= rem_d;
			full_q   <= full_d;
			zpend_q  <= zpend_d;
			count_q  <= count_d;
			tail0_q  <= tail0_d;
			tail1_q  <= tail1_d;
			crc_q    <= crc_d;
			vmatch_q <= vmatch_d;
			type_q   <= type_d;
			seq_q    <= seq_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/cobs_crc_frame_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// path: an accepted input beat is held in the input register, and its result is
//   registered in the result register
// throughput: one encoded byte per cycle while no byte with a result meets a stalled
//   output, limited by the crc byte step and cobs counter update in the frame core
// reset: arst_n clears frame state and the valid bits of both stages, and sets
//   protocol_version to 1
// ----------------------------------------------------------------------------
// cobs_crc_frame_decoder
// COBS deframer with CRC-16-CCITT check: input register, frame core,
// result register.
// ----------------------------------------------------------------------------
module cobs_crc_frame_decoder #(
	parameter int unsigned MAX_BODY_BYTES = cobs_pkg::MAX_BODY_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             out_kind,
	output logic [7:0]       body_byte,
	output logic [2:0]       frame_status,
	output logic [7:0]       message_type,
	output logic [15:0]      sequence_number,
	output logic [8:0]       body_length
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        version_q;
	logic              out_free;
	logic              adv;
	cobs_pkg::result_t res;
	cobs_pkg::result_t res_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;
	// a beat that yields no result never waits on the output side
	assign adv       = valid_s1 && (!res.emit || out_free);
	assign in_stall  = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= cobs_pkg::VER_RESET;
		end else if (cfg_valid) begin
			version_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	cobs_frame_core #(
		.MAX_BODY_BYTES(MAX_BODY_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.byte_in (byte_s1),
		.version (version_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && res.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			res_q <= res;
		end
	end

	assign out_kind        = res_q.kind;
	assign body_byte       = res_q.body;
	assign frame_status    = res_q.status;
	assign message_type    = res_q.msg_type;
	assign sequence_number = res_q.seq;
	assign body_length     = res_q.len;

endmodule
`default_nettype wire

@@ test/tb_cobs_crc_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cobs_crc_frame_decoder
// Self-checking bench for the COBS deframer with CRC-16-CCITT check. A short
// table of hand-picked byte sequences runs first, then random frames (clean,
// corrupted, truncated and noisy) under several protocol versions. Both sides
// idle at random. Output beats are compared against a local decode model, or against the table for typed rows.
// ----------------------------------------------------------------------------
module tb_cobs_crc_frame_decoder;

	localparam int BODY_MAX  = int'(cobs_pkg::MAX_BODY_BYTES_DEF);
	localparam int FRAME_MIN = cobs_pkg::HEADER_LEN + cobs_pkg::CRC_LEN;

	typedef struct packed {
		cobs_pkg::kind_t   kind;
		logic [7:0]        body;
		cobs_pkg::status_t status;
		logic [7:0]        mtype;
		logic [15:0]       seq;
		logic [8:0]        len;
	} beat_t;

	typedef struct packed {
		logic [7:0]        b;
		logic              typed;
		cobs_pkg::status_t st;
		logic [7:0]        mt;
		logic [15:0]       sq;
	} row_t;

	// typed rows carry the status beat their terminator must produce
	localparam row_t DIR_TAB [22] = '{
		'{8'h00, 1'b1, cobs_pkg::ST_SHORT,    8'h00, 16'h0000},
		'{8'h03, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h01, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h02, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h00, 1'b1, cobs_pkg::ST_SHORT,    8'h02, 16'h0000},
		'{8'h05, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h01, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'hFF, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h00, 1'b1, cobs_pkg::ST_BAD_COBS, 8'hFF, 16'h0000},
		'{8'h04, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h01, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h22, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h33, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h00, 1'b1, cobs_pkg::ST_SHORT,    8'h22, 16'h0033},
		'{8'h05, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h01, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'hAB, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h34, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h12, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h01, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h01, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000},
		'{8'h00, 1'b0, cobs_pkg::ST_OK,       8'h00, 16'h0000}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic        out_kind;
	logic [7:0]  body_byte;
	logic [2:0]  frame_status;
	logic [7:0]  message_type;
	logic [15:0] sequence_number;
	logic [8:0]  body_length;

	// decode model state
	logic [7:0]  version_reg;
	logic [7:0]  blk_left;
	logic        blk_full;
	logic        zero_owed;
	logic [8:0]  pay_cnt;
	logic [7:0]  tail0;
	logic [7:0]  tail1;
	logic [15:0] crc_acc;
	logic        ver_ok;
	logic [7:0]  hold_type;
	logic [15:0] hold_seq;

	beat_t       pending_beats[$];
	beat_t       exp_beat;
	int          fails;
	int          sent_bytes;
	bit          in_quiet;
	bit          out_quiet;
	int          stall_left;
	int          out_roll;

	cobs_crc_frame_decoder uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_byte         (in_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_kind        (out_kind),
		.body_byte       (body_byte),
		.frame_status    (frame_status),
		.message_type    (message_type),
		.sequence_number (sequence_number),
		.body_length     (body_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// bitwise msb-first ccitt step
	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0} ^ (fb ? cobs_pkg::CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic void restart_frame();
		blk_left  = 8'h00;
		blk_full  = 1'b0;
		zero_owed = 1'b0;
		pay_cnt   = 9'd0;
		tail0     = 8'h00;
		tail1     = 8'h00;
		crc_acc   = cobs_pkg::CRC_INIT;
		ver_ok    = 1'b0;
		hold_type = 8'h00;
		hold_seq  = 16'h0000;
	endfunction

	// push one decoded byte through the two-byte crc delay line
	function automatic bit take_payload(input logic [7:0] b, output logic [7:0] out_b);
		bit emit;
		emit = 1'b0;
		out_b = 8'h00;
		case (pay_cnt)
			9'd0: ver_ok = (b == version_reg);
			9'd1: hold_type = b;
			9'd2: hold_seq[7:0] = b;
			9'd3: hold_seq[15:8] = b;
			default: ;
		endcase
		if (pay_cnt >= cobs_pkg::CRC_LEN) begin
			crc_acc = crc16_step(crc_acc, tail0);
			if (pay_cnt >= FRAME_MIN) begin
				out_b = tail0;
				emit = 1'b1;
			end
		end
		tail0 = tail1;
		tail1 = b;
		if (pay_cnt != cobs_pkg::COUNT_MAX) pay_cnt++;
		return emit;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output beat_t r);
		logic [7:0] bd;
		bit emit;
		r = '0;
		bd = 8'h00;
		emit = 1'b0;
		if (b == 8'h00) begin
			r.kind = cobs_pkg::KIND_STATUS;
			if (blk_left != 0) r.status = cobs_pkg::ST_BAD_COBS;
			else if (pay_cnt < FRAME_MIN) r.status = cobs_pkg::ST_SHORT;
			else if (pay_cnt > FRAME_MIN + BODY_MAX) r.status = cobs_pkg::ST_LONG;
			else if ({tail1, tail0} != crc_acc) r.status = cobs_pkg::ST_BAD_CRC;
			else if (!ver_ok) r.status = cobs_pkg::ST_BAD_VER;
			else begin
				r.status = cobs_pkg::ST_OK;
				r.len = 9'(pay_cnt - FRAME_MIN);
			end
			r.mtype = hold_type;
			r.seq = hold_seq;
			restart_frame();
			return 1'b1;
		end
		if (blk_left == 0) begin
			// code byte: the zero owed by the previous short block lands now
			if (zero_owed) emit = take_payload(8'h00, bd);
			blk_left = b - 8'd1;
			blk_full = (b == cobs_pkg::CODE_FULL);
		end else begin
			emit = take_payload(b, bd);
			blk_left--;
		end
		zero_owed = (blk_left == 0) && !blk_full;
		r.kind = cobs_pkg::KIND_BODY;
		r.body = bd;
		return emit;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (in_quiet || r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit use_given, input beat_t given);
		beat_t r;
		bit has;
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		in_byte = b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		has = decode_byte(b, r);
		if (use_given) pending_beats.insert(pending_beats.size(), given);
		else if (has) pending_beats.insert(pending_beats.size(), r);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			in_byte = 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_version(input logic [7:0] v);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		version_reg = v;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = 8'($urandom);
	endtask

	// a clean frame carries the current version, a good crc and no damage
	task automatic send_frame(input int body_len, input bit clean);
		logic [7:0] pay[$];
		logic [7:0] enc[$];
		logic [15:0] c;
		int code_at;
		int code;
		int density;
		int cut;
		int fault;
		beat_t none;
		none = '0;
		if ($urandom_range(0, 5) == 0) in_quiet = !in_quiet;
		pay.insert(pay.size(),
			(!clean && $urandom_range(0, 9) == 0) ? 8'($urandom) : version_reg);
		repeat (3) pay.insert(pay.size(), 8'($urandom));
		density = $urandom_range(0, 2);
		for (int i = 0; i < body_len; i++) begin
			case (density)
				0: pay.insert(pay.size(), 8'($urandom_range(1, 255)));
				1: pay.insert(pay.size(), 8'($urandom));
				default: pay.insert(pay.size(),
					($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
			endcase
		end
		c = cobs_pkg::CRC_INIT;
		foreach (pay[i]) c = crc16_step(c, pay[i]);
		if (!clean && $urandom_range(0, 7) == 0) c ^= 16'h0001 << $urandom_range(0, 15);
		pay.insert(pay.size(), c[7:0]);
		pay.insert(pay.size(), c[15:8]);
		// payload cut to at most five bytes now and then, from empty to just past the header
		if (!clean && $urandom_range(0, 19) == 0) begin
			cut = $urandom_range(0, 5);
			while (pay.size() > cut) void'(pay.pop_back());
		end
		code_at = 0;
		code = 1;
		enc.insert(enc.size(), 8'h00);
		foreach (pay[i]) begin
			if (pay[i] == 8'h00) begin
				enc[code_at] = 8'(code);
				code_at = enc.size();
				enc.insert(enc.size(), 8'h00);
				code = 1;
			end else begin
				enc.insert(enc.size(), pay[i]);
				code++;
				if (code == 255) begin
					enc[code_at] = 8'(code);
					code_at = enc.size();
					enc.insert(enc.size(), 8'h00);
					code = 1;
				end
			end
		end
		enc[code_at] = 8'(code);
		fault = clean ? 19 : $urandom_range(0, 19);
		if (fault == 0) begin
			cut = $urandom_range(0, enc.size() - 1);
			while (enc.size() > cut) void'(enc.pop_back());
		end else if (fault == 1) begin
			repeat ($urandom_range(1, 8)) enc.insert(enc.size(), 8'($urandom));
		end
		enc.insert(enc.size(), 8'h00);
		foreach (enc[i]) send_byte(enc[i], 1'b0, none);
		sent_bytes += enc.size();
	endtask

	// random output stalls, with quiet stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall = 1'b0;
			out_quiet = 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
			out_roll = $urandom_range(0, 99);
			if (out_quiet || out_roll < 70) begin
				out_stall = 1'b0;
			end else if (out_roll < 95) begin
				out_stall = 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_stall = 1'b1;
				stall_left = $urandom_range(5, 20);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				fails++;
				if (fails <= 30)
					$display("%0t: unexpected beat, expected none, got kind=%0d b=%02h st=%0d",
						$time, out_kind, body_byte, frame_status);
			end else begin
				exp_beat = pending_beats.pop_front();
				if (out_kind !== exp_beat.kind || body_byte !== exp_beat.body ||
						frame_status !== exp_beat.status || message_type !== exp_beat.mtype ||
						sequence_number !== exp_beat.seq || body_length !== exp_beat.len) begin
					fails++;
					if (fails <= 30) begin
						$display("%0t: expected kind=%0d b=%02h st=%0d t=%02h sq=%04h n=%0d",
							$time, exp_beat.kind, exp_beat.body, exp_beat.status,
							exp_beat.mtype, exp_beat.seq, exp_beat.len);
						$display("%0t: actual   kind=%0d b=%02h st=%0d t=%02h sq=%04h n=%0d",
							$time, out_kind, body_byte, frame_status, message_type,
							sequence_number, body_length);
					end
				end
			end
		end
	end

	initial begin
		beat_t given;
		logic [7:0] phase_ver [4];
		int frames;
		int start;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		in_byte = 8'h00;
		arst_n = 1'b0;
		version_reg = cobs_pkg::VER_RESET;
		restart_frame();
		in_quiet = 1'b0;
		fails = 0;
		sent_bytes = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIR_TAB[i]) begin
			given = '0;
			given.kind = cobs_pkg::KIND_STATUS;
			given.status = DIR_TAB[i].st;
			given.mtype = DIR_TAB[i].mt;
			given.seq = DIR_TAB[i].sq;
			send_byte(DIR_TAB[i].b, DIR_TAB[i].typed, given);
		end

		phase_ver = '{8'h00, 8'hFF, 8'($urandom), cobs_pkg::VER_RESET};
		foreach (phase_ver[p]) begin
			write_version(phase_ver[p]);
			frames = 0;
			start = sent_bytes;
			while (sent_bytes - start < 30) begin
				// largest legal body once, one byte over the limit once
				if (p == 1 && frames == 0) send_frame(BODY_MAX, 1'b1);
				else if (p == 2 && frames == 0) send_frame(BODY_MAX + 1, 1'b1);
				else send_frame($urandom_range(0, 12), 1'b0);
				frames++;
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
